@@ hw/rtl/gbt_pkg.sv @@
`timescale 1ns / 1ps

package gbt_pkg;

    // Default sizes of the graph store
    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_DEGREE_DEF   = 8;
    localparam int WORK_DEPTH_DEF   = 16;

    // Visits emitted by one traversal at most
    localparam int RESULT_LIMIT = 16;
    localparam int NW           = $clog2(RESULT_LIMIT + 1);

    // Stream payload widths
    localparam int NAME_W     = 8;
    localparam int IN_DATA_W  = 2 * NAME_W;
    localparam int OUT_DATA_W = NAME_W;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR      = 2'd0,
        KIND_ADD_VERTEX = 2'd1,
        KIND_ADD_EDGE   = 2'd2,
        KIND_TRAVERSE   = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_VISIT      = 2'd0,
        STAT_UNKNOWN    = 2'd1,
        STAT_TABLE_FULL = 2'd2,
        STAT_ADJ_FULL   = 2'd3
    } status_t;

    // Read address source of the name memory
    typedef enum logic [1:0] {
        NRD_SCAN      = 2'd0,
        NRD_SCAN_NEXT = 2'd1,
        NRD_U         = 2'd2,
        NRD_V         = 2'd3
    } name_rsel_t;

    // Read address source of the degree memory
    typedef enum logic [1:0] {
        DRD_A = 2'd0,
        DRD_B = 2'd1,
        DRD_V = 2'd2
    } deg_rsel_t;

    // Controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       cnt_clear;
        logic       vtx_add;
        logic       scan_start;
        logic       scan_step;
        logic       tgt_b;
        logic       found_a;
        logic       found_b;
        name_rsel_t name_rsel;
        deg_rsel_t  deg_rsel;
        logic       latch_deg_a;
        logic       edge_wr1;
        logic       edge_wr2;
        logic       trav_init;
        logic       trav_bfs;
        logic       work_rd_tail;
        logic       head_pop;
        logic       v_load;
        logic       k_clear;
        logic       k_inc;
        logic       u_load;
        logic       mark_u;
        logic       mark_v;
        logic       push_u;
        logic       tail_dec;
        logic       emit_visit;
        logic       emit_err;
        status_t    err_code;
        logic       err_name_b;
        logic       finish;
    } gbt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic  in_valid;
        kind_t kind;
        logic  mode;
        logic  cnt_full;
        logic  cnt_zero;
        logic  scan_match;
        logic  scan_end;
        logic  adj_full;
        logic  head_lt_tail;
        logic  tail_zero;
        logic  tail_full;
        logic  k_lt_deg;
        logic  u_visited;
        logic  v_visited;
        logic  n_lim;
        logic  can_emit;
        logic  out_free;
    } gbt_stat_t;

endpackage

@@ hw/rtl/graph_bfs_dfs_traversal_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  tdata                      tuser         tlast
// s_        in   [7:0] name_a [15:8] name_b [1:0] kind    -
// m_        out  [7:0] vertex_name          [1:0] status  last
// cfg_      in   cfg_wdata = traversal_mode (written when cfg_we is high)
//
// Clear and add vertex requests pass through accept and decode.
// Name lookups scan the name memory one entry per cycle; an edge add
// looks up a, then b, then reads both degrees and writes both slots; a
// traversal reads each visited vertex's adjacency slots in turn.
// Reset clears the vertex count, visited marks and the traversal mode.
// A stalled result channel holds the walk; no request is taken meanwhile.

module graph_bfs_dfs_traversal_core #(
    parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = gbt_pkg::MAX_DEGREE_DEF,
    parameter int WORK_DEPTH   = gbt_pkg::WORK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gbt_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] name_a, [15:8] name_b
    input  logic [gbt_pkg::KIND_W-1:0]     s_tuser,  // [1:0] kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gbt_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] vertex_name
    output logic [gbt_pkg::STAT_W-1:0]     m_tuser,  // [1:0] status
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata
);
    import gbt_pkg::*;

    gbt_cmd_t  cmd;
    gbt_stat_t stat;

    gbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    gbt_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .WORK_DEPTH   (WORK_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign s_tready = cmd.in_ready;

endmodule

@@ hw/rtl/gbt_ram.sv @@
`timescale 1ns / 1ps

module gbt_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/gbt_ctrl.sv @@
`timescale 1ns / 1ps

module gbt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  gbt_pkg::gbt_stat_t stat,
    output gbt_pkg::gbt_cmd_t  cmd
);
    import gbt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_LK_RD, ST_LK_CMP,
        ST_ED_RDA, ST_ED_RDB, ST_ED_CHK, ST_ED_WR2,
        ST_BF_POP, ST_BF_V, ST_BF_A, ST_BF_K, ST_BF_U, ST_BF_M, ST_BF_N,
        ST_DF_TOP, ST_DF_V, ST_DF_A, ST_DF_B, ST_DF_K, ST_DF_U,
        ST_FIN, ST_ERR
    } state_t;

    state_t  state_reg, state_next;
    logic    tgt_b_reg, tgt_b_next;
    logic    err_b_reg, err_b_next;
    status_t err_code_reg, err_code_next;

    // Decode state into commands and next state
    always_comb begin
        cmd            = '0;
        cmd.name_rsel  = NRD_V;
        cmd.deg_rsel   = DRD_V;
        cmd.tgt_b      = tgt_b_reg;
        cmd.err_code   = err_code_reg;
        cmd.err_name_b = err_b_reg;
        state_next     = state_reg;
        tgt_b_next     = tgt_b_reg;
        err_b_next     = err_b_reg;
        err_code_next  = err_code_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.kind)
                    KIND_CLEAR: begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    KIND_ADD_VERTEX: begin
                        if (stat.cnt_full) begin
                            err_code_next = STAT_TABLE_FULL;
                            err_b_next    = 1'b0;
                            state_next    = ST_ERR;
                        end else begin
                            cmd.vtx_add = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                    default: begin
                        if (stat.cnt_zero) begin
                            err_code_next = STAT_UNKNOWN;
                            err_b_next    = 1'b0;
                            state_next    = ST_ERR;
                        end else begin
                            cmd.scan_start = 1'b1;
                            tgt_b_next     = 1'b0;
                            state_next     = ST_LK_RD;
                        end
                    end
                endcase
            end
            ST_LK_RD: begin
                cmd.name_rsel = NRD_SCAN;
                state_next    = ST_LK_CMP;
            end
            ST_LK_CMP: begin
                cmd.name_rsel = NRD_SCAN_NEXT;
                if (stat.scan_match) begin
                    if (stat.kind == KIND_TRAVERSE) begin
                        cmd.found_a   = 1'b1;
                        cmd.trav_init = 1'b1;
                        cmd.trav_bfs  = !stat.mode;
                        state_next    = stat.mode ? ST_DF_TOP : ST_BF_POP;
                    end else if (!tgt_b_reg) begin
                        cmd.found_a    = 1'b1;
                        cmd.scan_start = 1'b1;
                        tgt_b_next     = 1'b1;
                        state_next     = ST_LK_RD;
                    end else begin
                        cmd.found_b = 1'b1;
                        state_next  = ST_ED_RDA;
                    end
                end else if (stat.scan_end) begin
                    err_code_next = STAT_UNKNOWN;
                    err_b_next    = tgt_b_reg;
                    state_next    = ST_ERR;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_ED_RDA: begin
                cmd.deg_rsel = DRD_A;
                state_next   = ST_ED_RDB;
            end
            ST_ED_RDB: begin
                cmd.deg_rsel    = DRD_B;
                cmd.latch_deg_a = 1'b1;
                state_next      = ST_ED_CHK;
            end
            ST_ED_CHK: begin
                cmd.deg_rsel = DRD_B;
                if (stat.adj_full) begin
                    err_code_next = STAT_ADJ_FULL;
                    err_b_next    = 1'b0;
                    state_next    = ST_ERR;
                end else begin
                    cmd.edge_wr1 = 1'b1;
                    state_next   = ST_ED_WR2;
                end
            end
            ST_ED_WR2: begin
                cmd.edge_wr2 = 1'b1;
                state_next   = ST_IDLE;
            end
            // Breadth first walk
            ST_BF_POP: begin
                if (stat.head_lt_tail && !stat.n_lim) begin
                    cmd.head_pop = 1'b1;
                    state_next   = ST_BF_V;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_BF_V: begin
                cmd.v_load = 1'b1;
                state_next = ST_BF_A;
            end
            ST_BF_A: begin
                cmd.k_clear = 1'b1;
                state_next  = ST_BF_K;
            end
            ST_BF_K: begin
                if (stat.k_lt_deg && !stat.n_lim) begin
                    state_next = ST_BF_U;
                end else begin
                    state_next = ST_BF_POP;
                end
            end
            ST_BF_U: begin
                cmd.u_load = 1'b1;
                if (!stat.u_visited) begin
                    cmd.mark_u = 1'b1;
                    cmd.push_u = !stat.tail_full;
                    state_next = ST_BF_M;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_BF_K;
                end
            end
            ST_BF_M: begin
                cmd.name_rsel = NRD_U;
                state_next    = ST_BF_N;
            end
            ST_BF_N: begin
                cmd.name_rsel = NRD_U;
                if (stat.can_emit) begin
                    cmd.emit_visit = 1'b1;
                    cmd.k_inc      = 1'b1;
                    state_next     = ST_BF_K;
                end
            end
            // Depth first walk, list rescanned from its head
            ST_DF_TOP: begin
                cmd.work_rd_tail = 1'b1;
                if (!stat.tail_zero && !stat.n_lim) begin
                    state_next = ST_DF_V;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DF_V: begin
                cmd.v_load = 1'b1;
                state_next = ST_DF_A;
            end
            ST_DF_A: begin
                state_next = ST_DF_B;
            end
            ST_DF_B: begin
                if (stat.v_visited) begin
                    cmd.k_clear = 1'b1;
                    state_next  = ST_DF_K;
                end else if (stat.can_emit) begin
                    cmd.emit_visit = 1'b1;
                    cmd.mark_v     = 1'b1;
                    cmd.k_clear    = 1'b1;
                    state_next     = ST_DF_K;
                end
            end
            ST_DF_K: begin
                if (stat.k_lt_deg) begin
                    state_next = ST_DF_U;
                end else begin
                    cmd.tail_dec = 1'b1;
                    state_next   = ST_DF_TOP;
                end
            end
            ST_DF_U: begin
                if (!stat.u_visited) begin
                    cmd.push_u   = !stat.tail_full;
                    cmd.tail_dec = stat.tail_full;
                    state_next   = ST_DF_TOP;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_DF_K;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered error selection
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tgt_b_reg    <= 1'b0;
            err_b_reg    <= 1'b0;
            err_code_reg <= STAT_VISIT;
        end else begin
            state_reg    <= state_next;
            tgt_b_reg    <= tgt_b_next;
            err_b_reg    <= err_b_next;
            err_code_reg <= err_code_next;
        end
    end

endmodule

@@ hw/rtl/gbt_dp.sv @@
`timescale 1ns / 1ps

module gbt_dp #(
    parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = gbt_pkg::MAX_DEGREE_DEF,
    parameter int WORK_DEPTH   = gbt_pkg::WORK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [gbt_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [gbt_pkg::KIND_W-1:0]     s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [gbt_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [gbt_pkg::STAT_W-1:0]     m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  gbt_pkg::gbt_cmd_t              cmd,
    output gbt_pkg::gbt_stat_t             stat
);
    import gbt_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int SD  = MAX_VERTICES * MAX_DEGREE;
    localparam int SW  = $clog2(SD);
    localparam int WW  = $clog2(WORK_DEPTH + 1);
    localparam int WAW = $clog2(WORK_DEPTH);

    // Captured request and control registers
    logic              mode_reg;
    kind_t             kind_reg;
    logic [NAME_W-1:0] a_reg, b_reg;
    logic [CW-1:0]     cnt_reg;
    logic [VW-1:0]     idx_reg, ia_reg, ib_reg, v_reg, u_reg;
    logic [DW-1:0]     deg_a_reg, deg_b_reg, k_reg;
    logic [WW-1:0]     head_reg, tail_reg;
    logic [NW-1:0]     n_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [NAME_W-1:0] pend_name_reg, out_name_reg;
    logic              pend_valid_reg, out_valid_reg, out_last_reg;
    status_t           out_stat_reg;

    // Memory ports
    logic              name_we;
    logic [VW-1:0]     name_waddr, name_raddr;
    logic [NAME_W-1:0] name_rdata;
    logic              deg_we;
    logic [VW-1:0]     deg_waddr, deg_raddr;
    logic [DW-1:0]     deg_wdata, deg_rdata;
    logic              slot_we;
    logic [SW-1:0]     slot_waddr, slot_raddr;
    logic [VW-1:0]     slot_wdata, slot_rdata;
    logic              work_we;
    logic [WAW-1:0]    work_waddr, work_raddr;
    logic [VW-1:0]     work_wdata, work_rdata;

    logic              self_edge, out_free;
    logic [DW:0]       deg_a_ext;
    logic [WW-1:0]     tail_m1;
    logic [NAME_W-1:0] scan_target;

    assign self_edge   = (ia_reg == ib_reg);
    assign deg_a_ext   = {1'b0, deg_a_reg};
    assign tail_m1     = tail_reg - WW'(1);
    assign scan_target = cmd.tgt_b ? b_reg : a_reg;
    assign out_free    = !out_valid_reg || m_tready;

    // Status toward the controller
    always_comb begin
        stat.in_valid   = s_tvalid;
        stat.kind       = kind_reg;
        stat.mode       = mode_reg;
        stat.cnt_full   = (cnt_reg == CW'(MAX_VERTICES));
        stat.cnt_zero   = (cnt_reg == '0);
        stat.scan_match = (name_rdata == scan_target);
        stat.scan_end   = ((CW'(idx_reg) + CW'(1)) == cnt_reg);
        if (self_edge) begin
            stat.adj_full = (deg_a_ext + (DW+1)'(2)) > (DW+1)'(MAX_DEGREE);
        end else begin
            stat.adj_full = (deg_a_reg >= DW'(MAX_DEGREE)) ||
                            (deg_rdata >= DW'(MAX_DEGREE));
        end
        stat.head_lt_tail = (head_reg < tail_reg);
        stat.tail_zero    = (tail_reg == '0);
        stat.tail_full    = (tail_reg == WW'(WORK_DEPTH));
        stat.k_lt_deg     = (k_reg < deg_rdata);
        stat.u_visited    = visited_reg[slot_rdata];
        stat.v_visited    = visited_reg[v_reg];
        stat.n_lim        = (n_reg == NW'(RESULT_LIMIT));
        stat.can_emit     = !pend_valid_reg || out_free;
        stat.out_free     = out_free;
    end

    // Memory address and data selection
    always_comb begin
        case (cmd.name_rsel)
            NRD_SCAN:      name_raddr = idx_reg;
            NRD_SCAN_NEXT: name_raddr = idx_reg + VW'(1);
            NRD_U:         name_raddr = u_reg;
            default:       name_raddr = v_reg;
        endcase
        case (cmd.deg_rsel)
            DRD_A:   deg_raddr = ia_reg;
            DRD_B:   deg_raddr = ib_reg;
            default: deg_raddr = v_reg;
        endcase

        name_we    = cmd.vtx_add;
        name_waddr = cnt_reg[VW-1:0];

        deg_we = cmd.vtx_add || cmd.edge_wr1 || cmd.edge_wr2;
        if (cmd.edge_wr1) begin
            deg_waddr = ia_reg;
            deg_wdata = deg_a_reg + DW'(1);
        end else if (cmd.edge_wr2) begin
            deg_waddr = ib_reg;
            deg_wdata = deg_b_reg + DW'(1);
        end else begin
            deg_waddr = cnt_reg[VW-1:0];
            deg_wdata = '0;
        end

        slot_we    = cmd.edge_wr1 || cmd.edge_wr2;
        slot_raddr = SW'(v_reg) * SW'(MAX_DEGREE) + SW'(k_reg);
        if (cmd.edge_wr1) begin
            slot_waddr = SW'(ia_reg) * SW'(MAX_DEGREE) + SW'(deg_a_reg);
            slot_wdata = ib_reg;
        end else begin
            slot_waddr = SW'(ib_reg) * SW'(MAX_DEGREE) + SW'(deg_b_reg);
            slot_wdata = ia_reg;
        end

        work_we    = cmd.trav_init || cmd.push_u;
        work_waddr = cmd.trav_init ? '0 : tail_reg[WAW-1:0];
        work_wdata = cmd.trav_init ? idx_reg : slot_rdata;
        work_raddr = cmd.work_rd_tail ? tail_m1[WAW-1:0] : head_reg[WAW-1:0];
    end

    gbt_ram #(.WIDTH(NAME_W), .DEPTH(MAX_VERTICES)) u_name_ram (
        .clk(aclk), .we(name_we), .waddr(name_waddr), .wdata(a_reg),
        .raddr(name_raddr), .rdata(name_rdata)
    );

    gbt_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk(aclk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    gbt_ram #(.WIDTH(VW), .DEPTH(SD)) u_slot_ram (
        .clk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    gbt_ram #(.WIDTH(VW), .DEPTH(WORK_DEPTH)) u_work_ram (
        .clk(aclk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            cnt_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            n_reg          <= '0;
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.cnt_clear) begin
                cnt_reg <= '0;
            end else if (cmd.vtx_add) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            // Work list pointers, visit count and visited marks
            if (cmd.trav_init) begin
                head_reg    <= '0;
                tail_reg    <= WW'(1);
                n_reg       <= cmd.trav_bfs ? NW'(1) : '0;
                visited_reg <= cmd.trav_bfs ? (MAX_VERTICES'(1) << idx_reg) : '0;
            end else begin
                if (cmd.head_pop) begin
                    head_reg <= head_reg + WW'(1);
                end
                if (cmd.push_u) begin
                    tail_reg <= tail_reg + WW'(1);
                end else if (cmd.tail_dec) begin
                    tail_reg <= tail_m1;
                end
                if (cmd.emit_visit) begin
                    n_reg <= n_reg + NW'(1);
                end
                if (cmd.mark_u) begin
                    visited_reg[slot_rdata] <= 1'b1;
                end
                if (cmd.mark_v) begin
                    visited_reg[v_reg] <= 1'b1;
                end
            end
            // Pending visit and output slot
            if ((cmd.emit_visit && pend_valid_reg) || cmd.finish || cmd.emit_err) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.emit_visit || (cmd.trav_init && cmd.trav_bfs)) begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.in_ready && s_tvalid) begin
            kind_reg <= kind_t'(s_tuser);
            a_reg    <= s_tdata[NAME_W-1:0];
            b_reg    <= s_tdata[IN_DATA_W-1:NAME_W];
        end
        if (cmd.scan_start) begin
            idx_reg <= '0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + VW'(1);
        end
        if (cmd.found_a) begin
            ia_reg <= idx_reg;
        end
        if (cmd.found_b) begin
            ib_reg <= idx_reg;
        end
        if (cmd.latch_deg_a) begin
            deg_a_reg <= deg_rdata;
        end
        if (cmd.edge_wr1) begin
            deg_b_reg <= self_edge ? (deg_a_reg + DW'(1)) : deg_rdata;
        end
        if (cmd.v_load) begin
            v_reg <= work_rdata;
        end
        if (cmd.u_load) begin
            u_reg <= slot_rdata;
        end
        if (cmd.k_clear) begin
            k_reg <= '0;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + DW'(1);
        end
        if (cmd.trav_init) begin
            pend_name_reg <= a_reg;
        end
        if (cmd.emit_visit) begin
            pend_name_reg <= name_rdata;
            if (pend_valid_reg) begin
                out_name_reg <= pend_name_reg;
                out_stat_reg <= STAT_VISIT;
                out_last_reg <= 1'b0;
            end
        end
        if (cmd.finish) begin
            out_name_reg <= pend_name_reg;
            out_stat_reg <= STAT_VISIT;
            out_last_reg <= 1'b1;
        end
        if (cmd.emit_err) begin
            out_name_reg <= cmd.err_name_b ? b_reg : a_reg;
            out_stat_reg <= cmd.err_code;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_name_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/gbt_checker.sv @@
`timescale 1ns / 1ps

module gbt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gbt_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [gbt_pkg::STAT_W-1:0]     m_tuser,
    input logic                          m_tlast
);
    import gbt_pkg::*;

    // A stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // An error is always the only and final result of its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_VISIT) |-> m_tlast)
        else $error("error result without last");

    // A request is decoded before the next one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back to back request taken");

    // Reset empties the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind graph_bfs_dfs_traversal_core gbt_checker u_gbt_checker (.*);
